[rtl/core/hcp_pkg.sv]
package hcp_pkg;

    localparam int LINE_LEN  = 7;
    localparam int COUNT_MAX = 15;
    localparam int COUNT_W   = 4;
    localparam int IDX_W     = 3;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] DIGIT_LO   = 8'd48;
    localparam logic [7:0] DIGIT_HI   = 8'd57;
    localparam logic [7:0] ALPHA_LO   = 8'd65;
    localparam logic [7:0] ALPHA_HI   = 8'd70;
    localparam logic [7:0] ALPHA_BASE = 8'd55;

    typedef logic [7:0]              t_char;
    typedef t_char [LINE_LEN-1:0]    t_line;
    typedef logic [COUNT_W-1:0]      t_count;

    typedef struct packed {
        logic       ok;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_parse;

    // {valid, nibble}; uppercase hex only
    function automatic logic [4:0] hex_nibble(input t_char ch);
        logic [7:0] d;
        logic [4:0] res;
        d   = 8'd0;
        res = 5'd0;
        if (ch >= DIGIT_LO && ch <= DIGIT_HI) begin
            d   = ch - DIGIT_LO;
            res = {1'b1, d[3:0]};
        end else if (ch >= ALPHA_LO && ch <= ALPHA_HI) begin
            d   = ch - ALPHA_BASE;
            res = {1'b1, d[3:0]};
        end
        return res;
    endfunction

endpackage

[rtl/core/hcp_line_parser.sv]
module hcp_line_parser (
    input  hcp_pkg::t_line  i_line,
    input  hcp_pkg::t_count i_count,
    input  hcp_pkg::t_char  i_byte,
    output hcp_pkg::t_parse o_parse
);
    import hcp_pkg::*;

    logic [4:0]              nib [1:LINE_LEN-1];
    logic [LINE_LEN-1:1]     hex_ok;

    always_comb begin
        for (int k = 1; k < LINE_LEN; k++) begin
            nib[k]    = hex_nibble(i_line[k]);
            hex_ok[k] = nib[k][4];
        end
    end

    always_comb begin
        o_parse.ok    = (i_byte == CHAR_CR) && (i_count == COUNT_W'(LINE_LEN))
                        && (i_line[0] == CHAR_HASH) && (&hex_ok);
        o_parse.red   = {nib[1][3:0], nib[2][3:0]};
        o_parse.green = {nib[3][3:0], nib[4][3:0]};
        o_parse.blue  = {nib[5][3:0], nib[6][3:0]};
    end

endmodule

[rtl/core/hex_color_command_parser.sv]
// Hex color command parser.
// Slave stream: one received character per transfer in s_tdata[7:0].
// Master stream: one result per input character. m_tdata carries the echoed
// byte and the current red, green and blue duty levels; m_tuser flags that
// this byte was the CR closing a valid "#RRGGBB" line (uppercase hex only).
// An accepted character passes through the input register and then the result
// register before it is presented on the master side, once that register is free.
// Throughput: one character per cycle while the receiver takes results; the
// input register feeds the parse logic and the state update directly, and the
// result register is the only stage after it.
// A result waiting on the master side does not block the slave side until
// the input register also holds an item.
// Reset clears the count, the duty levels and both valid flags; the line
// store is not cleared, since a parse reads only characters of its own line.
// When the receiver stalls, the result holds and the input register fills,
// then s_tready drops until the result is taken.
module hex_color_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] echo_byte, [15:8] red_duty,
                                     // [23:16] green_duty, [31:24] blue_duty
    output logic        o_m_tuser    // [0] color_update
);
    import hcp_pkg::*;

    logic   r_in_valid;
    t_char  r_in_byte;
    logic   r_out_valid;
    t_char  r_out_echo;
    logic   r_out_update;
    t_line  r_line;
    t_count r_char_count, n_char_count;
    logic [7:0] r_red, r_green, r_blue;
    logic [7:0] n_red, n_green, n_blue;
    t_parse parse;
    logic   advance;

    hcp_line_parser u_parser (
        .i_line  (r_line),
        .i_count (r_char_count),
        .i_byte  (r_in_byte),
        .o_parse (parse)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_comb begin
        n_char_count = r_char_count;
        if (r_in_byte == CHAR_CR) begin
            n_char_count = '0;
        end else if (r_char_count < COUNT_W'(COUNT_MAX)) begin
            n_char_count = r_char_count + COUNT_W'(1);
        end
        n_red   = parse.ok ? parse.red   : r_red;
        n_green = parse.ok ? parse.green : r_green;
        n_blue  = parse.ok ? parse.blue  : r_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_char_count <= '0;
            r_red        <= 8'd0;
            r_green      <= 8'd0;
            r_blue       <= 8'd0;
        end else begin
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_char_count <= n_char_count;
                r_red        <= n_red;
                r_green      <= n_green;
                r_blue       <= n_blue;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_echo   <= r_in_byte;
            r_out_update <= parse.ok;
            // characters past the seventh are dropped
            if (r_in_byte != CHAR_CR && r_char_count < COUNT_W'(LINE_LEN)) begin
                r_line[r_char_count[IDX_W-1:0]] <= r_in_byte;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_blue, r_green, r_red, r_out_echo};
    assign o_m_tuser  = r_out_update;

    a_update_on_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[7:0] == CHAR_CR))
        else $error("color update on a non-CR byte");

    a_cr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_byte == CHAR_CR) |=> (r_char_count == '0))
        else $error("count not cleared after CR");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_byte != CHAR_CR && r_char_count < COUNT_W'(COUNT_MAX))
        |=> (r_char_count == $past(r_char_count) + COUNT_W'(1)))
        else $error("count did not advance");

    a_levels_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && parse.ok) |=> ($stable(r_red) && $stable(r_green) && $stable(r_blue)))
        else $error("duty levels changed without a valid command");

    a_stall_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready && r_in_valid) |-> !o_s_tready)
        else $error("accepted with both registers full");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import hcp_pkg::*;

    localparam int RANDOM_CHARS = 800;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PRINT_CAP    = 50;

    typedef struct {
        t_char      echo;
        logic       update;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color_result;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} t_rx_mode;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;    // [7:0] rx_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;             // [7:0] echo, [15:8] red, [23:16] green, [31:24] blue
    logic        o_m_tuser;             // [0] color_update

    // parser state as seen from the line
    t_char      line_buf [LINE_LEN];
    t_count     char_cnt;
    logic [7:0] red_lvl, green_lvl, blue_lvl;

    t_color_result pending_colors[$];

    int mismatch_count = 0;
    int chars_sent     = 0;
    int burst_left     = 0;
    int cycle_count    = 0;
    bit hold_req       = 0;
    int hold_cycles    = 0;

    hex_color_command_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_colors.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic bit is_upper_hex(t_char c);
        return (c >= DIGIT_LO && c <= DIGIT_HI) || (c >= ALPHA_LO && c <= ALPHA_HI);
    endfunction

    function automatic logic [3:0] digit_val(t_char c);
        t_char v;
        v = (c <= DIGIT_HI) ? c - DIGIT_LO : c - ALPHA_BASE;
        return v[3:0];
    endfunction

    function automatic t_char rand_hex_digit();
        string digits;
        digits = "0123456789ABCDEF";
        return t_char'(digits[$urandom_range(0, 15)]);
    endfunction

    // any byte but CR
    function automatic t_char rand_text_char();
        t_char c;
        c = t_char'($urandom_range(0, 254));
        if (c >= CHAR_CR)
            c = c + 8'd1;
        return c;
    endfunction

    task automatic reset_line_state();
        char_cnt  = '0;
        red_lvl   = 8'h00;
        green_lvl = 8'h00;
        blue_lvl  = 8'h00;
        foreach (line_buf[k])
            line_buf[k] = 8'h00;
    endtask

    // advance the line parser by one accepted char and queue the result it must give
    task automatic track_char(input t_char ch);
        t_color_result r;
        bit ok;
        ok = 1'b0;
        if (ch != CHAR_CR) begin
            if (char_cnt < COUNT_W'(LINE_LEN))
                line_buf[char_cnt[IDX_W-1:0]] = ch;
            if (char_cnt < COUNT_W'(COUNT_MAX))
                char_cnt = char_cnt + COUNT_W'(1);
        end else begin
            if (char_cnt == COUNT_W'(LINE_LEN) && line_buf[0] == CHAR_HASH) begin
                ok = 1'b1;
                for (int k = 1; k < LINE_LEN; k++)
                    if (!is_upper_hex(line_buf[k]))
                        ok = 1'b0;
            end
            if (ok) begin
                red_lvl   = {digit_val(line_buf[1]), digit_val(line_buf[2])};
                green_lvl = {digit_val(line_buf[3]), digit_val(line_buf[4])};
                blue_lvl  = {digit_val(line_buf[5]), digit_val(line_buf[6])};
            end
            char_cnt = '0;
        end
        r.echo   = ch;
        r.update = ok;
        r.red    = red_lvl;
        r.green  = green_lvl;
        r.blue   = blue_lvl;
        pending_colors.push_back(r);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_color_result r;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (pending_colors.size() == 0) begin
                report_mismatch("unexpected transfer", o_m_tdata, 32'h0);
            end else begin
                r = pending_colors.pop_front();
                if (o_m_tdata[7:0] !== r.echo)
                    report_mismatch("echo_byte", 32'(o_m_tdata[7:0]), 32'(r.echo));
                if (o_m_tuser !== r.update)
                    report_mismatch("color_update", 32'(o_m_tuser), 32'(r.update));
                if (o_m_tdata[15:8] !== r.red)
                    report_mismatch("red_duty", 32'(o_m_tdata[15:8]), 32'(r.red));
                if (o_m_tdata[23:16] !== r.green)
                    report_mismatch("green_duty", 32'(o_m_tdata[23:16]), 32'(r.green));
                if (o_m_tdata[31:24] !== r.blue)
                    report_mismatch("blue_duty", 32'(o_m_tdata[31:24]), 32'(r.blue));
            end
        end
    end

    // receiver: switches among stall patterns, or holds off on request
    initial begin
        t_rx_mode mode;
        int mode_left;
        int phase;
        mode      = RX_ALWAYS;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_req = 0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 400);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_ALWAYS:  i_m_tready <= 1'b1;
                    RX_RANDOM:  i_m_tready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: i_m_tready <= (phase % 5 != 2) && (phase % 7 != 0);
                    default:    i_m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // one char per call; valid stays up across back-to-back transfers in a burst
    task automatic send_char(input t_char ch);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        track_char(ch);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(t_char'(s[k]));
    endtask

    task automatic wait_results();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_colors.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_valid_commands();
        send_text("#FFFFFF");
        send_char(CHAR_CR);
        wait_results();
    endtask

    task automatic test_rejected_lines();
        send_char(CHAR_CR);                 // empty line
        send_text("#00000f");               // lowercase digit
        send_char(CHAR_CR);
        send_char(8'h00);                   // short, no '#', byte extremes
        send_char(8'hFF);
        send_char(CHAR_CR);
        send_text("#0000000");              // one char too many
        send_char(CHAR_CR);
        wait_results();
    endtask

    task automatic send_random_line();
        t_char cmd [LINE_LEN];
        string bad;
        int pick;
        int pos;
        int n;
        bad  = "/:@G`gaf#";
        pick = $urandom_range(0, 99);
        cmd[0] = CHAR_HASH;
        for (int k = 1; k < LINE_LEN; k++)
            cmd[k] = rand_hex_digit();
        if (pick < 60) begin
            foreach (cmd[k]) send_char(cmd[k]);
            send_char(CHAR_CR);
        end else if (pick < 72) begin
            pos = $urandom_range(0, LINE_LEN - 1);
            case ($urandom_range(0, 2))
                0:       cmd[pos] = t_char'(bad[$urandom_range(0, bad.len() - 1)]);
                1:       cmd[pos] = t_char'($urandom_range(97, 102));
                default: cmd[pos] = rand_text_char();
            endcase
            foreach (cmd[k]) send_char(cmd[k]);
            send_char(CHAR_CR);
        end else if (pick < 82) begin
            // valid head followed by extra chars; covers count saturation
            foreach (cmd[k]) send_char(cmd[k]);
            n = $urandom_range(1, 24);
            repeat (n) send_char(($urandom_range(0, 1) == 0) ? rand_hex_digit()
                                                             : rand_text_char());
            send_char(CHAR_CR);
        end else if (pick < 90) begin
            n = $urandom_range(0, LINE_LEN - 1);
            for (int k = 0; k < n; k++) send_char(cmd[k]);
            send_char(CHAR_CR);
        end else begin
            n = $urandom_range(1, 12);
            repeat (n) send_char(($urandom_range(0, 4) == 0) ? CHAR_CR
                                                             : t_char'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        hold_req    = 1;
        repeat (12) send_random_line();
        wait_results();
    endtask

    task automatic test_random_stream();
        int start;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS)
            send_random_line();
        wait_results();
    endtask

    initial begin
        reset_line_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_valid_commands();
        test_rejected_lines();
        test_backpressure();
        test_random_stream();

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
